[sv/vda_pkg.sv]
// shared types, widths and arctangent table for the vector distance and angle block
package vda_pkg;

   localparam int COORD_W = 16;
   localparam int DIFF_W = COORD_W + 1;
   localparam int FRAC_BITS = 8;
   localparam int VEC_W = 28;
   localparam int ACC_W = 32;
   localparam int DIST_W = 17;
   localparam int ANGLE_W = 16;
   localparam int TABLE_LEN = 24;
   localparam int GAIN_W = 32;
   localparam int PROD_W = VEC_W - 1 + GAIN_W;
   localparam int SCALE_SHIFT = 32 + FRAC_BITS;

   localparam logic [GAIN_W-1:0] INV_GAIN = 32'd2608131496;
   localparam logic [ACC_W-1:0] HALF_TURN = 32'h8000_0000;
   localparam logic [ACC_W-1:0] ANGLE_ROUND = 32'h0000_8000;
   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   localparam logic [ACC_W-1:0] ATAN_TABLE [TABLE_LEN] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
      32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
      32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304,
      32'd652, 32'd326, 32'd163, 32'd81
   };

   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
   } points_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic [ACC_W-1:0] acc;
      logic degenerate;
   } vec_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [ANGLE_W-1:0] angle;
      logic degenerate;
   } result_type;

endpackage

[sv/vda_prep.sv]
// difference vector, coincidence test and half-turn pre-rotation stage
module vda_prep (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  vda_pkg::points_type in_data,
   output logic out_valid,
   input  logic out_ready,
   output vda_pkg::vec_type out_data
);
   import vda_pkg::*;

   logic valid_ff;
   vec_type data_ff;
   vec_type data_in;
   logic signed [DIFF_W-1:0] dx;
   logic signed [DIFF_W-1:0] dy;
   logic signed [VEC_W-1:0] dx_s;
   logic signed [VEC_W-1:0] dy_s;

   always_comb begin
      dx = DIFF_W'(in_data.end_x) - DIFF_W'(in_data.start_x);
      dy = DIFF_W'(in_data.end_y) - DIFF_W'(in_data.start_y);
      dx_s = VEC_W'(dx) <<< FRAC_BITS;
      dy_s = VEC_W'(dy) <<< FRAC_BITS;
      data_in.degenerate = (dx == '0) && (dy == '0);
      // screen y grows downward, so the vector is (dx, -dy), turned by a half turn when dx is negative
      if (dx < 0) begin
         data_in.x = -dx_s;
         data_in.y = dy_s;
         data_in.acc = HALF_TURN;
      end else begin
         data_in.x = dx_s;
         data_in.y = -dy_s;
         data_in.acc = '0;
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

[sv/vda_rotate.sv]
// one cordic vectoring micro-rotation stage
module vda_rotate #(
   parameter int STEP = 0
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  vda_pkg::vec_type in_data,
   output logic out_valid,
   input  logic out_ready,
   output vda_pkg::vec_type out_data
);
   import vda_pkg::*;

   logic valid_ff;
   vec_type data_ff;
   vec_type data_in;
   logic signed [VEC_W-1:0] xs;
   logic signed [VEC_W-1:0] ys;

   always_comb begin
      xs = in_data.x >>> STEP;
      ys = in_data.y >>> STEP;
      data_in.degenerate = in_data.degenerate;
      if (in_data.y > 0) begin
         data_in.x = in_data.x + ys;
         data_in.y = in_data.y - xs;
         data_in.acc = in_data.acc + ATAN_TABLE[STEP];
      end else begin
         data_in.x = in_data.x - ys;
         data_in.y = in_data.y + xs;
         data_in.acc = in_data.acc - ATAN_TABLE[STEP];
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

[sv/vda_scale.sv]
// gain correction multiply and angle rounding, then distance rounding, saturation and clearing of coincident results
module vda_scale (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  vda_pkg::vec_type in_data,
   output logic out_valid,
   input  logic out_ready,
   output vda_pkg::result_type out_data
);
   import vda_pkg::*;

   logic mul_valid_ff;
   logic mul_ready;
   logic [PROD_W-1:0] prod_ff;
   logic [ANGLE_W-1:0] angle_ff;
   logic degen_ff;
   logic [VEC_W-2:0] x_mag;
   logic [ACC_W-1:0] acc_round;

   logic res_valid_ff;
   result_type res_ff;
   result_type res_in;
   logic [PROD_W-1:0] prod_round;
   logic [PROD_W-SCALE_SHIFT-1:0] dist_wide;

   // stage one: clamp, multiply by the inverse gain and round the angle
   always_comb begin
      x_mag = in_data.x[VEC_W-1] ? '0 : in_data.x[VEC_W-2:0];
      acc_round = in_data.acc + ANGLE_ROUND;
   end

   assign mul_ready = !res_valid_ff || out_ready;
   assign in_ready = !mul_valid_ff || mul_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (in_ready) begin
         mul_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         prod_ff <= PROD_W'(x_mag) * PROD_W'(INV_GAIN);
         angle_ff <= acc_round[ACC_W-1 -: ANGLE_W];
         degen_ff <= in_data.degenerate;
      end
   end

   // stage two: round, saturate, clear coincident results
   always_comb begin
      prod_round = prod_ff + (PROD_W'(1) << (SCALE_SHIFT - 1));
      dist_wide = prod_round[PROD_W-1:SCALE_SHIFT];
      res_in.degenerate = degen_ff;
      if (degen_ff) begin
         res_in.distance = '0;
         res_in.angle = '0;
      end else begin
         if (dist_wide > (PROD_W-SCALE_SHIFT)'(DIST_MAX)) begin
            res_in.distance = DIST_MAX;
         end else begin
            res_in.distance = dist_wide[DIST_W-1:0];
         end
         res_in.angle = angle_ff;
      end
   end

   assign out_valid = res_valid_ff;
   assign out_data = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else if (mul_ready) begin
         res_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_ready && mul_valid_ff) begin
         res_ff <= res_in;
      end
   end

endmodule

[sv/vector_distance_angle.sv]
// Distance and direction between two screen points by a pipelined CORDIC in vectoring
// mode. One transfer per cycle is accepted while the result output is not stalled; a result
// passes ITERATIONS + 3 register stages: one stage forms the difference vector, one stage
// per micro-rotation, one stage for the gain multiply and one for rounding. ITERATIONS
// above 24 acts as 24. Every stage holds its own valid bit and fills bubbles, so a stalled
// result only backs up the stages behind it. Angle is a binary angle, 65536 a full turn,
// counter-clockwise on screen from +x; coincident points give distance 0, angle 0 and the
// degenerate flag.
module vector_distance_angle #(
   parameter int ITERATIONS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [63:0] req_tdata,   // start_x, start_y, end_x, end_y
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [39:0] rsp_tdata,   // distance, angle, zero padding
   output logic rsp_tuser           // degenerate
);
   import vda_pkg::*;

   localparam int STEPS = (ITERATIONS > TABLE_LEN) ? TABLE_LEN : ITERATIONS;

   points_type points;
   result_type result;
   logic chain_valid [STEPS+1];
   logic chain_ready [STEPS+1];
   vec_type chain_data [STEPS+1];

   assign points.start_x = req_tdata[15:0];
   assign points.start_y = req_tdata[31:16];
   assign points.end_x = req_tdata[47:32];
   assign points.end_y = req_tdata[63:48];

   vda_prep u_prep (
      .clock(clock),
      .reset(reset),
      .in_valid(req_tvalid),
      .in_ready(req_tready),
      .in_data(points),
      .out_valid(chain_valid[0]),
      .out_ready(chain_ready[0]),
      .out_data(chain_data[0])
   );

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      vda_rotate #(
         .STEP(i)
      ) u_rotate (
         .clock(clock),
         .reset(reset),
         .in_valid(chain_valid[i]),
         .in_ready(chain_ready[i]),
         .in_data(chain_data[i]),
         .out_valid(chain_valid[i+1]),
         .out_ready(chain_ready[i+1]),
         .out_data(chain_data[i+1])
      );
   end

   vda_scale u_scale (
      .clock(clock),
      .reset(reset),
      .in_valid(chain_valid[STEPS]),
      .in_ready(chain_ready[STEPS]),
      .in_data(chain_data[STEPS]),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_data(result)
   );

   assign rsp_tdata = {7'd0, result.angle, result.distance};
   assign rsp_tuser = result.degenerate;

endmodule

[sv/vda_checker.sv]
// port-level assertions for the vector distance and angle block, bound to the top level
module vda_checker (
   input logic clock,
   input logic reset,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic rsp_tuser
);

   // pipeline is empty straight after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("pipeline not empty after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result transfer changed");

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[32:0] == 33'd0))
      else $error("coincident points gave non-zero result");

   a_padding_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[39:33] == 7'd0))
      else $error("result padding not zero");

endmodule

bind vector_distance_angle vda_checker u_vda_checker (
   .clock(clock),
   .reset(reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser)
);
